// File: rtl/cdrp_pkg.sv
package cdrp_pkg;

  localparam int INT_BITS     = 19;
  localparam int VALUE_W      = 36;
  localparam int OUT_COLS     = 4;
  localparam int SEEN_W       = 3;
  localparam int OUT_DATA_W   = 152;
  localparam int IN_DATA_W    = 8;

  localparam int COLUMNS_DEF         = 4;
  localparam int FRACTION_BITS_DEF   = 16;
  localparam int FRACTION_DIGITS_DEF = 5;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_POINT = 8'h2e;
  localparam logic [7:0] CH_COMMA = 8'h2c;
  localparam logic [7:0] CH_LF    = 8'h0a;

  localparam logic [INT_BITS-1:0] INT_MAX = {INT_BITS{1'b1}};

endpackage

// File: rtl/csv_decimal_row_parser.sv
// csv row parser: one text character per input item, one row of up to four
// signed fixed-point column values per result item.
// input channel: in_tdata carries the character, in_tlast marks end of text
// (character ignored, a started row is flushed). an item is taken when
// in_tvalid and in_tready are both high.
// output channel: out_tdata carries value_0..value_3, fields_seen, out_tuser
// the overflow flag. a newline always emits a row; end of text emits one only
// if the row was started.
// throughput: one item per cycle while in_tready is high. all parsing state
// (accumulators, column index, row store) updates in the cycle an item is
// taken; the row leaves through a single output register, so a result
// appears on the output in the cycle after the newline or end item is accepted.
// stall: while the output register holds an untaken row, in_tready follows
// out_tready, so the input keeps flowing as long as the receiver takes rows.
// reset clears the number and row state and empties the output register.
module csv_decimal_row_parser import cdrp_pkg::*; #(
  parameter int COLUMNS         = COLUMNS_DEF,
  parameter int FRACTION_BITS   = FRACTION_BITS_DEF,
  parameter int FRACTION_DIGITS = FRACTION_DIGITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // data_byte[7:0]
  input  logic                  in_tlast,   // end_of_text
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // value_0..value_3 (36 each), fields_seen, zero pad
  output logic                  out_tuser,  // overflow
  output logic                  out_tlast
);

  localparam int FB    = FRACTION_BITS;
  localparam int COL_W = $clog2(COLUMNS + 1);
  localparam int CNT_W = $clog2(FRACTION_DIGITS + 1);
  localparam int WT_N  = 2 ** CNT_W;
  localparam int MAG_W = INT_BITS + FB;
  localparam int EXT_W = (MAG_W > VALUE_W) ? MAG_W : VALUE_W;
  localparam logic [FB-1:0] FRAC_MAX = {FB{1'b1}};

  logic [FB-1:0] weight [WT_N];

  genvar gk;
  generate
    for (gk = 0; gk < WT_N; gk++) begin : g_wt
      if (gk < FRACTION_DIGITS) begin : g_on
        localparam longint unsigned P = 64'(10) ** (gk + 1);
        localparam longint unsigned W = ((64'd1 << FB) * 64'd2 + P) / (64'd2 * P);
        assign weight[gk] = W[FB-1:0];
      end else begin : g_off
        assign weight[gk] = '0;
      end
    end
  endgenerate

  logic                in_number_r, in_number_nxt;
  logic                negative_r, negative_nxt;
  logic                frac_mode_r, frac_mode_nxt;
  logic [INT_BITS-1:0] int_acc_r, int_acc_nxt;
  logic [FB-1:0]       frac_acc_r, frac_acc_nxt;
  logic [CNT_W-1:0]    frac_cnt_r, frac_cnt_nxt;
  logic [COL_W-1:0]    col_r, col_nxt;
  logic [VALUE_W-1:0]  row_vals_r [COLUMNS];
  logic [VALUE_W-1:0]  row_vals_nxt [COLUMNS];
  logic [VALUE_W-1:0]  stored_vals [COLUMNS];
  logic                row_ovf_r, row_ovf_nxt;
  logic                row_started_r, row_started_nxt;

  logic                  out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;
  logic                  out_user_r, out_user_nxt;

  logic                  accept;
  logic                  emit;
  logic                  store;
  logic                  clear_row;
  logic                  is_digit;
  logic [3:0]            dval;
  logic [INT_BITS+3:0]   int_sum;
  logic [FB+3:0]         frac_sum;
  logic [MAG_W-1:0]      mag;
  logic [EXT_W-1:0]      mag_ext;
  logic [EXT_W-1:0]      signed_ext;
  logic [VALUE_W-1:0]    store_val;
  logic                  ovf_sum;
  logic [SEEN_W-1:0]     seen;
  logic [VALUE_W-1:0]    emit_vals [OUT_COLS];

  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;

  assign is_digit = (in_tdata >= CH_ZERO) && (in_tdata <= CH_NINE);
  assign dval     = 4'(in_tdata - CH_ZERO);

  assign int_sum  = ({4'b0, int_acc_r} << 3) + ({4'b0, int_acc_r} << 1)
                  + (INT_BITS+4)'(dval);
  assign frac_sum = (FB+4)'(frac_acc_r) + (FB+4)'(dval) * (FB+4)'(weight[frac_cnt_r]);

  assign mag        = {int_acc_r, frac_acc_r};
  assign mag_ext    = EXT_W'(mag);
  assign signed_ext = negative_r ? (EXT_W'(0) - mag_ext) : mag_ext;
  assign store_val  = signed_ext[VALUE_W-1:0];

  always_comb begin
    in_number_nxt   = in_number_r;
    negative_nxt    = negative_r;
    frac_mode_nxt   = frac_mode_r;
    int_acc_nxt     = int_acc_r;
    frac_acc_nxt    = frac_acc_r;
    frac_cnt_nxt    = frac_cnt_r;
    col_nxt         = col_r;
    row_ovf_nxt     = row_ovf_r;
    row_started_nxt = row_started_r;
    store           = 1'b0;
    emit            = 1'b0;
    clear_row       = 1'b0;
    ovf_sum         = 1'b0;

    if (in_tlast) begin
      store     = in_number_r;
      emit      = row_started_r || in_number_r;
      clear_row = 1'b1;
    end else if (in_tdata == CH_LF) begin
      store     = in_number_r;
      emit      = 1'b1;
      clear_row = 1'b1;
    end else if (in_tdata == CH_COMMA) begin
      store           = in_number_r;
      row_started_nxt = 1'b1;
      if (col_r < COL_W'(COLUMNS)) begin
        col_nxt = col_r + COL_W'(1);
      end
    end else if (!in_number_r) begin
      if (is_digit || (in_tdata == CH_MINUS)) begin
        in_number_nxt   = 1'b1;
        row_started_nxt = 1'b1;
        negative_nxt    = (in_tdata == CH_MINUS);
        int_acc_nxt     = is_digit ? INT_BITS'(dval) : '0;
      end
    end else if (is_digit) begin
      if (!frac_mode_r) begin
        if (int_sum > (INT_BITS+4)'(INT_MAX)) begin
          int_acc_nxt = INT_MAX;
          ovf_sum     = 1'b1;
        end else begin
          int_acc_nxt = int_sum[INT_BITS-1:0];
        end
      end else if (frac_cnt_r < CNT_W'(FRACTION_DIGITS)) begin
        if (frac_sum > (FB+4)'(FRAC_MAX)) begin
          frac_acc_nxt = FRAC_MAX;
        end else begin
          frac_acc_nxt = frac_sum[FB-1:0];
        end
        frac_cnt_nxt = frac_cnt_r + CNT_W'(1);
      end
    end else if (in_tdata == CH_POINT) begin
      frac_mode_nxt = 1'b1;
    end

    if (ovf_sum) begin
      row_ovf_nxt = 1'b1;
    end

    for (int j = 0; j < COLUMNS; j++) begin
      stored_vals[j] = (store && (col_r == COL_W'(j))) ? store_val : row_vals_r[j];
      row_vals_nxt[j] = clear_row ? '0 : stored_vals[j];
    end

    if (store || clear_row) begin
      in_number_nxt = 1'b0;
      negative_nxt  = 1'b0;
      frac_mode_nxt = 1'b0;
      int_acc_nxt   = '0;
      frac_acc_nxt  = '0;
      frac_cnt_nxt  = '0;
    end
    if (clear_row) begin
      col_nxt         = '0;
      row_ovf_nxt     = 1'b0;
      row_started_nxt = 1'b0;
    end
  end

  genvar gj;
  generate
    for (gj = 0; gj < OUT_COLS; gj++) begin : g_out
      if (gj < COLUMNS) begin : g_col
        assign emit_vals[gj] = stored_vals[gj];
      end else begin : g_none
        assign emit_vals[gj] = '0;
      end
    end
  endgenerate

  always_comb begin
    if (!(row_started_r || in_number_r)) begin
      seen = '0;
    end else if (int'(col_r) >= 3) begin
      seen = SEEN_W'(4);
    end else begin
      seen = SEEN_W'(col_r) + SEEN_W'(1);
    end
    out_data_nxt = '0;
    for (int j = 0; j < OUT_COLS; j++) begin
      out_data_nxt[j*VALUE_W +: VALUE_W] = emit_vals[j];
    end
    out_data_nxt[OUT_COLS*VALUE_W +: SEEN_W] = seen;
    out_user_nxt = row_ovf_r || ovf_sum;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_number_r   <= 1'b0;
      negative_r    <= 1'b0;
      frac_mode_r   <= 1'b0;
      int_acc_r     <= '0;
      frac_acc_r    <= '0;
      frac_cnt_r    <= '0;
      col_r         <= '0;
      row_ovf_r     <= 1'b0;
      row_started_r <= 1'b0;
      for (int j = 0; j < COLUMNS; j++) begin
        row_vals_r[j] <= '0;
      end
    end else if (accept) begin
      in_number_r   <= in_number_nxt;
      negative_r    <= negative_nxt;
      frac_mode_r   <= frac_mode_nxt;
      int_acc_r     <= int_acc_nxt;
      frac_acc_r    <= frac_acc_nxt;
      frac_cnt_r    <= frac_cnt_nxt;
      col_r         <= col_nxt;
      row_ovf_r     <= row_ovf_nxt;
      row_started_r <= row_started_nxt;
      for (int j = 0; j < COLUMNS; j++) begin
        row_vals_r[j] <= row_vals_nxt[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept && emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      out_data_r <= out_data_nxt;
      out_user_r <= out_user_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign out_tlast  = 1'b1;

endmodule
